### rtl/core/dtq_pkg.sv
// shared types and constants for the deadline timer queue
// no dependencies; used by the interfaces, the cells, the control and the top level
package dtq_pkg;

	// default configuration
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TIME_BITS_DEF   = 48;
	localparam int ID_BITS_DEF     = 8;

	// at most this many expired entries leave the queue in one check
	localparam int MAX_RESULTS = 16;

	// command codes on the request channel
	typedef enum logic [1:0] {
		CMD_SCHED_ABS = 2'd0,
		CMD_SCHED_REL = 2'd1,
		CMD_CHECK     = 2'd2,
		CMD_NOP       = 2'd3
	} cmd_t;

	// per-cycle operation broadcast to every cell of the row
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_ctl_t;

endpackage

### rtl/core/dtq_req_if.sv
// request channel of the deadline timer queue: valid/ready plus command payload
// depends on dtq_pkg for default widths
interface dtq_req_if #(
	parameter int ID_BITS   = dtq_pkg::ID_BITS_DEF,
	parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           cmd;
	logic [ID_BITS-1:0]   entry_id;
	logic [TIME_BITS-1:0] time_value;
	logic [TIME_BITS-1:0] now_us;

	modport source (output valid, cmd, entry_id, time_value, now_us, input ready);
	modport sink   (input valid, cmd, entry_id, time_value, now_us, output ready);
endinterface

### rtl/core/dtq_rsp_if.sv
// result channel of the deadline timer queue: valid/ready plus result payload
// depends on dtq_pkg for default widths
interface dtq_rsp_if #(
	parameter int ID_BITS   = dtq_pkg::ID_BITS_DEF,
	parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic                 fired_valid;
	logic [ID_BITS-1:0]   fired_id;
	logic                 last;
	logic [TIME_BITS-1:0] rearm_delay;
	logic                 queue_empty;
	logic                 overflow;

	modport source (output valid, fired_valid, fired_id, last, rearm_delay, queue_empty,
		overflow, input ready);
	modport sink   (input valid, fired_valid, fired_id, last, rearm_delay, queue_empty,
		overflow, output ready);
endinterface

### rtl/core/deadline_timer_queue_core.sv
// top level of the deadline timer queue: a row of sorted cells and its sequencer
// depends on dtq_pkg, dtq_req_if, dtq_rsp_if, dtq_cell and dtq_ctrl
//
// channel  dir  handshake          payload
// req      in   req.valid/ready    cmd, entry_id, time_value, now_us
// rsp      out  rsp.valid/ready    fired_valid, fired_id, last, rearm_delay,
//                                  queue_empty, overflow
//
// a schedule is accepted, then inserts into the cell row unless full; a no-op inserts nothing
// a check pops one expired entry per cycle while rsp is free, up to MAX_RESULTS per check
// a result waiting on rsp holds the sequencer in its execute step; req waits meanwhile
// reset clears the sequencer state, fill count and result register; cell contents need no clearing
module deadline_timer_queue_core #(
	parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
	parameter int TIME_BITS   = dtq_pkg::TIME_BITS_DEF,
	parameter int ID_BITS     = dtq_pkg::ID_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dtq_req_if.sink   req,
	dtq_rsp_if.source rsp
);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	dtq_pkg::cell_ctl_t   ctl;
	logic [TIME_BITS-1:0] new_dl;
	logic [ID_BITS-1:0]   new_id;
	logic [CNT_W-1:0]     count;

	logic [TIME_BITS-1:0] dl_a [QUEUE_DEPTH];
	logic [ID_BITS-1:0]   id_a [QUEUE_DEPTH];
	logic                 f_a  [QUEUE_DEPTH];

	// row of cells, neighbors wired left to right
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                 occ;
		logic                 left_f;
		logic [TIME_BITS-1:0] left_dl;
		logic [ID_BITS-1:0]   left_id;
		logic [TIME_BITS-1:0] right_dl;
		logic [ID_BITS-1:0]   right_id;

		assign occ = CNT_W'(i) < count;

		if (i == 0) begin : g_head
			assign left_f  = 1'b0;
			assign left_dl = new_dl;
			assign left_id = new_id;
		end else begin : g_body
			assign left_f  = f_a[i-1];
			assign left_dl = dl_a[i-1];
			assign left_id = id_a[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_dl = dl_a[i];
			assign right_id = id_a[i];
		end else begin : g_inner
			assign right_dl = dl_a[i+1];
			assign right_id = id_a[i+1];
		end

		dtq_cell #(
			.TIME_BITS(TIME_BITS),
			.ID_BITS  (ID_BITS)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.occ     (occ),
			.new_dl  (new_dl),
			.new_id  (new_id),
			.left_f  (left_f),
			.left_dl (left_dl),
			.left_id (left_id),
			.right_dl(right_dl),
			.right_id(right_id),
			.dl      (dl_a[i]),
			.id      (id_a[i]),
			.f       (f_a[i])
		);
	end

	// sequencer sees the two head cells
	dtq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TIME_BITS  (TIME_BITS),
		.ID_BITS    (ID_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.head_dl0(dl_a[0]),
		.head_dl1(dl_a[1]),
		.head_id0(id_a[0]),
		.head_f0 (f_a[0]),
		.ctl     (ctl),
		.new_dl  (new_dl),
		.new_id  (new_id),
		.count   (count)
	);
endmodule

### rtl/core/dtq_cell.sv
// one slot of the sorted timer row: holds a deadline and an id
// depends on dtq_pkg (cell_ctl_t); besides the broadcast inputs, talks only to its left and right neighbors
module dtq_cell #(
	parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEF,
	parameter int ID_BITS   = dtq_pkg::ID_BITS_DEF
) (
	input  logic                 clk,
	input  dtq_pkg::cell_ctl_t   ctl,
	input  logic                 occ,
	input  logic [TIME_BITS-1:0] new_dl,
	input  logic [ID_BITS-1:0]   new_id,
	input  logic                 left_f,
	input  logic [TIME_BITS-1:0] left_dl,
	input  logic [ID_BITS-1:0]   left_id,
	input  logic [TIME_BITS-1:0] right_dl,
	input  logic [ID_BITS-1:0]   right_id,
	output logic [TIME_BITS-1:0] dl,
	output logic [ID_BITS-1:0]   id,
	output logic                 f
);
	logic [TIME_BITS-1:0] dl_q;
	logic [ID_BITS-1:0]   id_q;

	// slot lies at or after the insert point: empty, or strictly later deadline
	assign f  = !occ || (dl_q > new_dl);
	assign dl = dl_q;
	assign id = id_q;

	// pop shifts toward the head, insert shifts away from it
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			dl_q <= right_dl;
			id_q <= right_id;
		end else if (ctl.ins && f) begin
			if (left_f) begin
				dl_q <= left_dl;
				id_q <= left_id;
			end else begin
				dl_q <= new_dl;
				id_q <= new_id;
			end
		end
	end
endmodule

### rtl/core/dtq_ctrl.sv
// sequencer of the timer queue: takes commands, drives the cell row, builds results
// depends on dtq_pkg, dtq_req_if and dtq_rsp_if
module dtq_ctrl #(
	parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
	parameter int TIME_BITS   = dtq_pkg::TIME_BITS_DEF,
	parameter int ID_BITS     = dtq_pkg::ID_BITS_DEF,
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dtq_req_if.sink              req,
	dtq_rsp_if.source            rsp,
	input  logic [TIME_BITS-1:0] head_dl0,
	input  logic [TIME_BITS-1:0] head_dl1,
	input  logic [ID_BITS-1:0]   head_id0,
	input  logic                 head_f0,
	output dtq_pkg::cell_ctl_t   ctl,
	output logic [TIME_BITS-1:0] new_dl,
	output logic [ID_BITS-1:0]   new_id,
	output logic [CNT_W-1:0]     count
);
	localparam int N_W = $clog2(dtq_pkg::MAX_RESULTS);

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t               state_q;
	dtq_pkg::cmd_t        cmd_q;
	logic [ID_BITS-1:0]   id_q;
	logic [TIME_BITS-1:0] dl_q;
	logic [TIME_BITS-1:0] now_q;
	logic [CNT_W-1:0]     count_q;
	logic [N_W-1:0]       n_q;

	logic                 rsp_valid_q;
	logic                 fired_valid_q;
	logic [ID_BITS-1:0]   fired_id_q;
	logic                 last_q;
	logic [TIME_BITS-1:0] rearm_q;
	logic                 empty_q;
	logic                 ovf_q;

	logic                 accept;
	logic                 out_free;
	logic [TIME_BITS:0]   sum_w;
	logic [TIME_BITS-1:0] req_dl;
	logic                 full;
	logic                 due0;
	logic                 due1;
	logic                 pop_last;

	logic                 emit;
	logic                 e_valid;
	logic [ID_BITS-1:0]   e_id;
	logic                 e_last;
	logic                 e_has;
	logic [TIME_BITS-1:0] e_dl;
	logic                 e_empty;
	logic                 e_ovf;
	logic [TIME_BITS-1:0] e_rearm;
	logic                 done;

	// handshake and port drive
	assign req.ready       = (state_q == S_IDLE);
	assign accept          = req.valid && req.ready;
	assign out_free        = !rsp_valid_q || rsp.ready;
	assign rsp.valid       = rsp_valid_q;
	assign rsp.fired_valid = fired_valid_q;
	assign rsp.fired_id    = fired_id_q;
	assign rsp.last        = last_q;
	assign rsp.rearm_delay = rearm_q;
	assign rsp.queue_empty = empty_q;
	assign rsp.overflow    = ovf_q;
	assign new_dl          = dl_q;
	assign new_id          = id_q;
	assign count           = count_q;

	// deadline of a schedule: relative timeouts saturate at the top of the time range
	assign sum_w  = {1'b0, req.now_us} + {1'b0, req.time_value};
	assign req_dl = (dtq_pkg::cmd_t'(req.cmd) == dtq_pkg::CMD_SCHED_REL)
		? (sum_w[TIME_BITS] ? {TIME_BITS{1'b1}} : sum_w[TIME_BITS-1:0])
		: req.time_value;

	// head status seen by the sequencer
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign due0     = (count_q != '0) && (now_q >= head_dl0);
	assign due1     = (count_q > CNT_W'(1)) && (now_q >= head_dl1);
	assign pop_last = !due1 || (n_q == N_W'(dtq_pkg::MAX_RESULTS - 1));

	// result selection and row operation for the current cycle
	always_comb begin
		ctl     = '0;
		emit    = 1'b0;
		done    = 1'b0;
		e_valid = 1'b0;
		e_id    = '0;
		e_last  = 1'b1;
		e_has   = count_q != '0;
		e_dl    = head_dl0;
		e_empty = count_q == '0;
		e_ovf   = 1'b0;
		if (state_q == S_EXEC && out_free) begin
			emit = 1'b1;
			done = 1'b1;
			case (cmd_q)
				dtq_pkg::CMD_SCHED_ABS, dtq_pkg::CMD_SCHED_REL: begin
					ctl.ins = !full;
					e_ovf   = full;
					e_has   = 1'b1;
					e_dl    = (!full && head_f0) ? dl_q : head_dl0;
					e_empty = 1'b0;
				end
				dtq_pkg::CMD_CHECK: begin
					if (due0) begin
						ctl.pop = 1'b1;
						e_valid = 1'b1;
						e_id    = head_id0;
						e_last  = pop_last;
						e_has   = pop_last && (count_q > CNT_W'(1));
						e_dl    = head_dl1;
						e_empty = pop_last && (count_q == CNT_W'(1));
						done    = pop_last;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign e_rearm = (e_has && (e_dl > now_q)) ? (e_dl - now_q) : '0;

	// sequencer state, queue fill and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cmd_q         <= dtq_pkg::CMD_NOP;
			id_q          <= '0;
			dl_q          <= '0;
			now_q         <= '0;
			count_q       <= '0;
			n_q           <= '0;
			rsp_valid_q   <= 1'b0;
			fired_valid_q <= 1'b0;
			fired_id_q    <= '0;
			last_q        <= 1'b0;
			rearm_q       <= '0;
			empty_q       <= 1'b0;
			ovf_q         <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= S_EXEC;
				cmd_q   <= dtq_pkg::cmd_t'(req.cmd);
				id_q    <= req.entry_id;
				dl_q    <= req_dl;
				now_q   <= req.now_us;
				n_q     <= '0;
			end else if (done) begin
				state_q <= S_IDLE;
			end
			if (emit && !done) begin
				n_q <= n_q + N_W'(1);
			end
			if (ctl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (emit) begin
				rsp_valid_q   <= 1'b1;
				fired_valid_q <= e_valid;
				fired_id_q    <= e_id;
				last_q        <= e_last;
				rearm_q       <= e_last ? e_rearm : '0;
				empty_q       <= e_last && e_empty;
				ovf_q         <= e_ovf;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end
endmodule

### rtl/core/dtq_checker.sv
// port-level checks of the deadline timer queue, bound to the top level
// depends on dtq_pkg and deadline_timer_queue_core
module dtq_checker #(
	parameter int TIME_BITS = dtq_pkg::TIME_BITS_DEF,
	parameter int ID_BITS   = dtq_pkg::ID_BITS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic                 fired_valid,
	input logic [ID_BITS-1:0]   fired_id,
	input logic                 last,
	input logic [TIME_BITS-1:0] rearm_delay,
	input logic                 queue_empty,
	input logic                 overflow
);
	// a pending result stays until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped before transaction");

	// one command at a time: no new transaction right after one is taken
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a command is in flight");

	// status results carry no id
	a_status_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !fired_valid |-> last && fired_id == '0)
		else $error("status result with id or without last");

	// intermediate results are plain expirations with cleared status
	a_mid_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !last |-> fired_valid && rearm_delay == '0 && !queue_empty && !overflow)
		else $error("non-final result carries status");

	// a dropped schedule leaves a full, hence nonempty, queue
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && overflow |-> !fired_valid && !queue_empty)
		else $error("overflow with fired entry or empty queue");
endmodule

bind deadline_timer_queue_core dtq_checker #(
	.TIME_BITS(TIME_BITS),
	.ID_BITS  (ID_BITS)
) u_dtq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.fired_valid(rsp.fired_valid),
	.fired_id   (rsp.fired_id),
	.last       (rsp.last),
	.rearm_delay(rsp.rearm_delay),
	.queue_empty(rsp.queue_empty),
	.overflow   (rsp.overflow)
);

### bench/deadline_timer_queue_core_tb.sv
// self-checking bench for deadline_timer_queue_core: directed table, then random traffic
// depends on dtq_pkg, dtq_req_if, dtq_rsp_if and the deadline_timer_queue_core rtl
module deadline_timer_queue_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = dtq_pkg::QUEUE_DEPTH_DEF;
	localparam int TW    = dtq_pkg::TIME_BITS_DEF;
	localparam int IDW   = dtq_pkg::ID_BITS_DEF;
	localparam logic [TW-1:0] MAX_TIME = {TW{1'b1}};
	localparam int RANDOM_ITEMS   = 384;
	localparam int DIR_ROWS       = 26;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 40;

	// one result transaction
	typedef struct {
		logic           fired_valid;
		logic [IDW-1:0] fired_id;
		logic           last;
		logic [TW-1:0]  rearm_delay;
		logic           queue_empty;
		logic           overflow;
	} timer_event_t;

	// one row of the directed table
	typedef struct {
		dtq_pkg::cmd_t  cmd;
		logic [IDW-1:0] id;
		logic [TW-1:0]  tval;
		logic [TW-1:0]  now;
		bit             typed;
		timer_event_t   res;
	} stim_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	dtq_req_if req_ch ();
	dtq_rsp_if rsp_ch ();

	deadline_timer_queue_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the sorted queue
	logic [TW-1:0]  shadow_deadline [DEPTH];
	logic [IDW-1:0] shadow_id [DEPTH];
	int             shadow_count = 0;

	timer_event_t   due_events [$];
	int             mismatch_count = 0;
	int             stuck_cycles = 0;

	// typed expectation riding with the item currently on req
	bit             cur_typed = 1'b0;
	timer_event_t   cur_typed_res;

	stim_row_t      dir_table [DIR_ROWS];

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [TW-1:0] rand_time();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		return v[TW-1:0];
	endfunction

	// sorted insert after every entry with a deadline less than or equal
	function automatic bit shadow_insert(logic [IDW-1:0] id, logic [TW-1:0] dl);
		int pos;
		int i;
		if (shadow_count >= DEPTH)
			return 1'b0;
		pos = 0;
		while (pos < shadow_count && shadow_deadline[pos] <= dl)
			pos++;
		for (i = shadow_count; i > pos; i--) begin
			shadow_deadline[i] = shadow_deadline[i-1];
			shadow_id[i] = shadow_id[i-1];
		end
		shadow_deadline[pos] = dl;
		shadow_id[pos] = id;
		shadow_count++;
		return 1'b1;
	endfunction

	function automatic logic [IDW-1:0] shadow_pop();
		logic [IDW-1:0] id;
		int i;
		id = shadow_id[0];
		for (i = 1; i < shadow_count; i++) begin
			shadow_deadline[i-1] = shadow_deadline[i];
			shadow_id[i-1] = shadow_id[i];
		end
		shadow_count--;
		return id;
	endfunction

	function automatic logic [TW-1:0] rearm_from(logic [TW-1:0] nw);
		if (shadow_count == 0)
			return '0;
		return (shadow_deadline[0] > nw) ? shadow_deadline[0] - nw : '0;
	endfunction

	// expected results of one request transaction
	task automatic predict_timer_step(dtq_pkg::cmd_t c, logic [IDW-1:0] id,
		logic [TW-1:0] tv, logic [TW-1:0] nw);
		logic [TW-1:0]  dl;
		bit             ovf;
		logic [IDW-1:0] popped [$];
		timer_event_t   ev;
		int             k;
		ovf = 1'b0;
		case (c)
			dtq_pkg::CMD_SCHED_ABS: ovf = !shadow_insert(id, tv);
			dtq_pkg::CMD_SCHED_REL: begin
				dl = (tv > MAX_TIME - nw) ? MAX_TIME : nw + tv;
				ovf = !shadow_insert(id, dl);
			end
			dtq_pkg::CMD_CHECK: begin
				while (shadow_count > 0 && popped.size() < dtq_pkg::MAX_RESULTS &&
						nw >= shadow_deadline[0])
					popped.push_back(shadow_pop());
			end
			default: ;
		endcase
		for (k = 0; k < popped.size(); k++) begin
			ev.fired_valid = 1'b1;
			ev.fired_id    = popped[k];
			ev.last        = (k == popped.size() - 1);
			ev.rearm_delay = ev.last ? rearm_from(nw) : '0;
			ev.queue_empty = ev.last ? (shadow_count == 0) : 1'b0;
			ev.overflow    = 1'b0;
			due_events.push_back(ev);
		end
		// status-only result when nothing fired
		if (popped.size() == 0) begin
			ev.fired_valid = 1'b0;
			ev.fired_id    = '0;
			ev.last        = 1'b1;
			ev.rearm_delay = rearm_from(nw);
			ev.queue_empty = (shadow_count == 0);
			ev.overflow    = ovf;
			due_events.push_back(ev);
		end
	endtask

	task automatic check_field(string name, logic [TW-1:0] exp_v, logic [TW-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// monitor: predict on accepted requests, compare accepted results
	always @(posedge clk) begin
		timer_event_t exp_ev;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				predict_timer_step(dtq_pkg::cmd_t'(req_ch.cmd), req_ch.entry_id,
					req_ch.time_value, req_ch.now_us);
				if (cur_typed) begin
					void'(due_events.pop_back());
					due_events.push_back(cur_typed_res);
				end
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (due_events.size() == 0) begin
					$error("unexpected result transaction: fired_id %0h last %0b",
						rsp_ch.fired_id, rsp_ch.last);
					mismatch_count++;
				end else begin
					exp_ev = due_events.pop_front();
					check_field("fired_valid", exp_ev.fired_valid, rsp_ch.fired_valid);
					check_field("fired_id", exp_ev.fired_id, rsp_ch.fired_id);
					check_field("last", exp_ev.last, rsp_ch.last);
					check_field("rearm_delay", exp_ev.rearm_delay, rsp_ch.rearm_delay);
					check_field("queue_empty", exp_ev.queue_empty, rsp_ch.queue_empty);
					check_field("overflow", exp_ev.overflow, rsp_ch.overflow);
				end
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		@(posedge arst_n);
		while (stuck_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	// result side backpressure: always ready, coin flip, or on/off pattern
	initial begin
		int mode;
		int span;
		int k;
		int hold;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(40, 120);
			k = 0;
			while (k < span) begin
				@(negedge clk);
				k++;
				case (mode)
					0: rsp_ch.ready = 1'b1;
					1: rsp_ch.ready = 1'($urandom_range(0, 1));
					default: begin
						rsp_ch.ready = ~rsp_ch.ready;
						hold = rsp_ch.ready ? $urandom_range(1, 6) : $urandom_range(1, 10);
						repeat (hold - 1) @(negedge clk);
						k += hold - 1;
					end
				endcase
			end
		end
	end

	// drive one request transaction and hold it until accepted
	task automatic send_item(dtq_pkg::cmd_t c, logic [IDW-1:0] id, logic [TW-1:0] tv,
		logic [TW-1:0] nw, bit typed, timer_event_t res);
		@(negedge clk);
		req_ch.valid      = 1'b1;
		req_ch.cmd        = c;
		req_ch.entry_id   = id;
		req_ch.time_value = tv;
		req_ch.now_us     = nw;
		cur_typed         = typed;
		cur_typed_res     = res;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	task automatic idle_sender(int cycles);
		@(negedge clk);
		req_ch.valid = 1'b0;
		cur_typed = 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// hold off new requests until every expected result is in
	task automatic wait_drain();
		idle_sender(1);
		while (due_events.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		timer_event_t   no_res;
		timer_event_t   ev;
		logic [TW-1:0]  clock_now;
		logic [TW-1:0]  tv;
		logic [IDW-1:0] id;
		dtq_pkg::cmd_t  c;
		int             burst_left;
		int             fill_left;
		bit             flush_next;
		int             r;
		int             i;

		req_ch.valid      = 1'b0;
		req_ch.cmd        = dtq_pkg::CMD_NOP;
		req_ch.entry_id   = '0;
		req_ch.time_value = '0;
		req_ch.now_us     = '0;
		no_res = '{1'b0, '0, 1'b0, '0, 1'b0, 1'b0};

		// directed table: empty queue, extremes, ties, saturation, full queue
		dir_table[0] = '{dtq_pkg::CMD_CHECK, 8'h00, 48'h0, 48'h0, 1'b1,
			'{1'b0, 8'h00, 1'b1, 48'h0, 1'b1, 1'b0}};
		dir_table[1] = '{dtq_pkg::CMD_NOP, 8'h00, 48'h0, 48'h0, 1'b1,
			'{1'b0, 8'h00, 1'b1, 48'h0, 1'b1, 1'b0}};
		dir_table[2] = '{dtq_pkg::CMD_SCHED_ABS, 8'hff, MAX_TIME, 48'h0, 1'b1,
			'{1'b0, 8'h00, 1'b1, MAX_TIME, 1'b0, 1'b0}};
		dir_table[3] = '{dtq_pkg::CMD_SCHED_REL, 8'h00, MAX_TIME, 48'h1, 1'b0, no_res};
		dir_table[4] = '{dtq_pkg::CMD_SCHED_REL, 8'h01, 48'd50, 48'd10, 1'b0, no_res};
		dir_table[5] = '{dtq_pkg::CMD_SCHED_ABS, 8'haa, 48'd100, 48'd0, 1'b0, no_res};
		dir_table[6] = '{dtq_pkg::CMD_SCHED_ABS, 8'h55, 48'd100, 48'd0, 1'b0, no_res};
		dir_table[7] = '{dtq_pkg::CMD_CHECK, 8'h00, 48'h0, 48'd59, 1'b0, no_res};
		dir_table[8] = '{dtq_pkg::CMD_CHECK, 8'h00, 48'h0, 48'd100, 1'b0, no_res};
		for (i = 0; i < 14; i++)
			dir_table[9+i] = '{(i % 2) ? dtq_pkg::CMD_SCHED_REL : dtq_pkg::CMD_SCHED_ABS,
				8'(8'h10 + i), 48'(14000 - 1000 * i), 48'(i), 1'b0, no_res};
		dir_table[23] = '{dtq_pkg::CMD_SCHED_ABS, 8'h77, 48'd5, 48'd20000, 1'b1,
			'{1'b0, 8'h00, 1'b1, 48'h0, 1'b0, 1'b1}};
		dir_table[24] = '{dtq_pkg::CMD_CHECK, 8'h00, 48'h0, MAX_TIME, 1'b0, no_res};
		dir_table[25] = '{dtq_pkg::CMD_NOP, 8'h5a, 48'h5555_aaaa_5555, 48'd5, 1'b1,
			'{1'b0, 8'h00, 1'b1, 48'h0, 1'b1, 1'b0}};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// walk the directed table
		burst_left = $urandom_range(1, 8);
		for (i = 0; i < DIR_ROWS; i++) begin
			send_item(dir_table[i].cmd, dir_table[i].id, dir_table[i].tval,
				dir_table[i].now, dir_table[i].typed, dir_table[i].res);
			if (--burst_left == 0) begin
				idle_sender($urandom_range(1, 6));
				burst_left = $urandom_range(1, 8);
			end
		end
		wait_drain();

		// random traffic around a slowly advancing clock
		clock_now = '0;
		fill_left = 0;
		flush_next = 1'b0;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				clock_now = rand_time();
			else if (r < 7)
				clock_now = MAX_TIME - TW'($urandom_range(0, 300));
			else if (r < 9)
				clock_now = clock_now - TW'($urandom_range(0, 40));
			else
				clock_now = clock_now + TW'($urandom_range(0, 60));
			id = IDW'($urandom_range(0, 255));

			// occasional burst that fills the queue, then one check flushes it
			if (fill_left == 0 && !flush_next && $urandom_range(0, 99) < 3)
				fill_left = $urandom_range(16, 20);

			r = $urandom_range(0, 99);
			if (fill_left > 0) begin
				c = dtq_pkg::CMD_SCHED_REL;
				tv = TW'($urandom_range(0, 100));
				if (--fill_left == 0)
					flush_next = 1'b1;
			end else if (flush_next) begin
				clock_now = clock_now + TW'(1000);
				c = dtq_pkg::CMD_CHECK;
				tv = rand_time();
				flush_next = 1'b0;
			end else if (r < 25) begin
				c = dtq_pkg::CMD_SCHED_ABS;
				r = $urandom_range(0, 99);
				if (r < 10)
					tv = rand_time();
				else if (r < 20)
					tv = clock_now - TW'($urandom_range(0, 50));
				else
					tv = clock_now + TW'($urandom_range(0, 400));
			end else if (r < 50) begin
				c = dtq_pkg::CMD_SCHED_REL;
				r = $urandom_range(0, 99);
				if (r < 6)
					tv = rand_time();
				else if (r < 9)
					tv = MAX_TIME;
				else
					tv = TW'($urandom_range(0, 300));
			end else if (r < 95) begin
				c = dtq_pkg::CMD_CHECK;
				tv = rand_time();
			end else begin
				c = dtq_pkg::CMD_NOP;
				tv = rand_time();
			end

			send_item(c, id, tv, clock_now, 1'b0, no_res);

			// sender pacing: gap-free stretches, bursts with gaps, full drains at the midpoint and at random
			if (i == RANDOM_ITEMS / 2 || $urandom_range(0, 59) == 0) begin
				wait_drain();
			end else if ((i % 100) >= 25 && --burst_left <= 0) begin
				idle_sender($urandom_range(1, 6));
				burst_left = $urandom_range(1, 12);
			end
		end

		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
